FILE: hdl/svm_pkg.sv
// shared types and constants of the sample voice mixer
package svm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEN_W       = 16;
   localparam int VOL_W       = 15;
   localparam int DAC_W       = 12;
   localparam int FRAC_BITS   = 12;
   localparam int CLAMP_MAX   = 2047;
   localparam int CLAMP_MIN   = -2048;
   localparam int DAC_OFFSET  = 2048;

   localparam logic [VOL_W-1:0] VOL_RESET = 15'd4096;

   // register index, taken from bit 2 of the byte address
   localparam logic REG_MASTER_VOLUME = 1'b0;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_TRIGGER = 2'd1,
      FUNC_TICK    = 2'd2
   } svm_func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_LOAD_WR,
      S_SCAN,
      S_TRIG_WR,
      S_TICK,
      S_HAND
   } svm_state_type;

endpackage

FILE: hdl/svm_scale.sv
// volume multiply, floor shift, clamp and dac offset with output register
module svm_scale
   import svm_pkg::*;
#(
   parameter int SUM_W = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sum_valid,
   output logic                    sum_ready,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [VOL_W-1:0]        volume,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DAC_W-1:0]        rsp_dac_code
);

   localparam int PROD_W = SUM_W + VOL_W + 1;
   localparam logic signed [PROD_W-1:0] MAX_S = PROD_W'(CLAMP_MAX);
   localparam logic signed [PROD_W-1:0] MIN_S = PROD_W'(CLAMP_MIN);

   logic                     prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     out_valid_ff, out_valid_in;
   logic [DAC_W-1:0]         out_ff, out_in;
   logic                     out_take;
   logic signed [PROD_W-1:0] shifted;
   logic signed [PROD_W-1:0] clamped;

   // exact product, sum is signed and volume unsigned
   assign prod_in = PROD_W'(sum) * PROD_W'($signed({1'b0, volume}));

   assign out_take  = prod_valid_ff && (!out_valid_ff || !rsp_stall);
   assign sum_ready = !prod_valid_ff || out_take;

   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      if (shifted > MAX_S) begin
         clamped = MAX_S;
      end else if (shifted < MIN_S) begin
         clamped = MIN_S;
      end else begin
         clamped = shifted;
      end
      out_in        = DAC_W'(clamped) + DAC_W'(DAC_OFFSET);
      prod_valid_in = (sum_valid && sum_ready) || (prod_valid_ff && !out_take);
      out_valid_in  = out_take || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid && sum_ready) begin
         prod_ff <= prod_in;
      end
      if (out_take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dac_code = out_ff;

endmodule

FILE: hdl/sample_voice_mixer_top.sv
// top level of the sample voice mixer
// Polyphonic sample playback mixer. A load transfer writes one signed word into the sample
// memory, a trigger transfer starts the voice with the fewest remaining samples (lowest number
// on a tie, so a busy voice is stolen when all are in use) and a tick transfer mixes one output
// sample. Voice pointers and counts sit in a small voice memory, samples in a sample memory with
// separate write and read ports, both read through a register; one item is worked on at a time.
// A tick walks the voice memory one voice per cycle and fetches one sample per cycle, and waits
// in its hand-off state only while both result registers are full; the scaled result then
// leaves through a product register and an output register, so the next item is accepted
// while a result still waits.
// A load or trigger first brings its address into range with a subtract-and-compare loop of
// 17 - log2(SAMPLE_WORDS) steps (one step for 65536 words or more); a load then writes the word,
// a trigger then scans the voice memory and writes the chosen voice. There is no clearing pass:
// the voice memory has a valid bit per voice, and unwritten sample words read as whatever the
// memory holds. The master volume register (4096 is unity) sits at byte address 0 of the csr
// port and must be written only while the block is idle; the block itself does not enforce it.
module sample_voice_mixer_top
   import svm_pkg::*;
#(
   parameter int VOICES       = 16,
   parameter int SAMPLE_WORDS = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_func,
   input  logic [15:0]                req_mem_address,
   input  logic signed [15:0]         req_mem_data,
   input  logic [15:0]                req_voice_start,
   input  logic [15:0]                req_voice_length,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [11:0]                rsp_dac_code,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int AW        = $clog2(SAMPLE_WORDS);
   localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW        = $clog2(VOICES + 1);
   localparam int SUM_W     = SAMPLE_W + ((VOICES > 1) ? $clog2(VOICES) : 0);
   localparam int RED_STEPS = (AW >= 17) ? 1 : 17 - AW;
   localparam int SW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
   localparam int CMP_W     = (AW > 16) ? AW + 2 : 19;
   localparam int ENTRY_W   = AW + LEN_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLE_WORDS - 1);

   // control and item registers
   svm_state_type             state_ff, state_in;
   svm_func_type              func_ff;
   logic signed [15:0]        data_ff;
   logic [LEN_W-1:0]          len_ff;
   logic [15:0]               red_ff, red_in;
   logic [SW-1:0]             step_ff, step_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [VW-1:0]             best_idx_ff, best_idx_in;
   logic [LEN_W:0]            best_rem_ff, best_rem_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic [VOL_W-1:0]          master_volume_ff, master_volume_in;

   // voice memory read stage
   logic                      rd_live_ff;
   logic [VW-1:0]             rd_idx_ff;
   logic [ENTRY_W-1:0]        rd_entry_ff;
   logic                      rd_valid_ff;
   logic [VOICES-1:0]         voice_valid_ff;
   logic [ENTRY_W-1:0]        voice_mem [VOICES];

   // sample memory read stage
   logic                      smp_live_ff;
   logic signed [15:0]        smp_q_ff;
   logic signed [15:0]        sample_mem [SAMPLE_WORDS];

   logic                      req_take;
   logic                      issue;
   logic [VW-1:0]             raddr;
   logic [AW-1:0]             cur_ptr;
   logic [LEN_W-1:0]          cur_rem;
   logic [AW-1:0]             next_ptr;
   logic                      active;
   logic                      vwr_en;
   logic [VW-1:0]             vwr_idx;
   logic [ENTRY_W-1:0]        vwr_data;
   logic                      swr_en;
   logic [AW-1:0]             red_addr;
   logic [CMP_W-1:0]          cmp_const;
   logic                      red_ge;
   logic                      sum_valid;
   logic                      sum_ready;
   logic                      cfg_wr;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // address range reduction, one quotient bit per step
   assign cmp_const = CMP_W'(SAMPLE_WORDS) << step_ff;
   assign red_ge    = CMP_W'(red_ff) >= cmp_const;
   assign red_addr  = AW'(red_ff);

   // voice walk, one voice read per cycle
   assign issue = ((state_ff == S_SCAN) || (state_ff == S_TICK)) && (cnt_ff < CW'(VOICES));
   assign raddr = cnt_ff[VW-1:0];

   // a voice never written reads as idle at address zero
   assign cur_ptr  = rd_valid_ff ? rd_entry_ff[ENTRY_W-1:LEN_W] : '0;
   assign cur_rem  = rd_valid_ff ? rd_entry_ff[LEN_W-1:0] : '0;
   assign next_ptr = (cur_ptr == LAST_ADDR) ? '0 : cur_ptr + AW'(1);
   assign active   = rd_live_ff && (state_ff == S_TICK) && (cur_rem != '0);

   // next state and control
   always_comb begin
      state_in  = state_ff;
      sum_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_func)
                  FUNC_LOAD, FUNC_TRIGGER: state_in = S_REDUCE;
                  FUNC_TICK:               state_in = S_TICK;
                  default:                 state_in = S_IDLE;
               endcase
            end
         end
         S_REDUCE: begin
            if (step_ff == '0) begin
               state_in = (func_ff == FUNC_LOAD) ? S_LOAD_WR : S_SCAN;
            end
         end
         S_LOAD_WR: state_in = S_IDLE;
         S_SCAN: begin
            if ((cnt_ff == CW'(VOICES)) && !rd_live_ff) begin
               state_in = S_TRIG_WR;
            end
         end
         S_TRIG_WR: state_in = S_IDLE;
         S_TICK: begin
            if ((cnt_ff == CW'(VOICES)) && !rd_live_ff && !smp_live_ff) begin
               state_in = S_HAND;
            end
         end
         S_HAND: begin
            sum_valid = 1'b1;
            if (sum_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      red_in      = red_ff;
      step_in     = step_ff;
      cnt_in      = '0;
      best_idx_in = best_idx_ff;
      best_rem_in = {1'b1, {LEN_W{1'b0}}};
      acc_in      = acc_ff;
      if (state_ff == S_IDLE) begin
         red_in  = (req_func == FUNC_LOAD) ? req_mem_address : req_voice_start;
         step_in = SW'(RED_STEPS - 1);
         acc_in  = '0;
      end
      if (state_ff == S_REDUCE) begin
         if (red_ge) begin
            red_in = red_ff - cmp_const[15:0];
         end
         step_in = step_ff - SW'(1);
      end
      if ((state_ff == S_SCAN) || (state_ff == S_TICK)) begin
         cnt_in = issue ? cnt_ff + CW'(1) : cnt_ff;
      end
      if (state_ff == S_SCAN) begin
         best_rem_in = best_rem_ff;
         if (rd_live_ff && ({1'b0, cur_rem} < best_rem_ff)) begin
            best_idx_in = rd_idx_ff;
            best_rem_in = {1'b0, cur_rem};
         end
      end
      if ((state_ff == S_TICK) && smp_live_ff) begin
         acc_in = acc_ff + SUM_W'(smp_q_ff);
      end
   end

   // voice memory write port: tick write-back or trigger
   always_comb begin
      vwr_en   = 1'b0;
      vwr_idx  = rd_idx_ff;
      vwr_data = {next_ptr, cur_rem - LEN_W'(1)};
      if (active) begin
         vwr_en = 1'b1;
      end else if (state_ff == S_TRIG_WR) begin
         vwr_en   = 1'b1;
         vwr_idx  = best_idx_ff;
         vwr_data = {red_addr, len_ff};
      end
   end

   assign swr_en = (state_ff == S_LOAD_WR);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         cnt_ff           <= '0;
         rd_live_ff       <= 1'b0;
         smp_live_ff      <= 1'b0;
         voice_valid_ff   <= '0;
         master_volume_ff <= VOL_RESET;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         rd_live_ff       <= issue;
         smp_live_ff      <= active;
         master_volume_ff <= master_volume_in;
         if (vwr_en) begin
            voice_valid_ff[vwr_idx] <= 1'b1;
         end
      end
   end

   // item and datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= svm_func_type'(req_func);
         data_ff <= req_mem_data;
         len_ff  <= req_voice_length;
      end
      red_ff      <= red_in;
      step_ff     <= step_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      acc_ff      <= acc_in;
      rd_idx_ff   <= raddr;
      rd_valid_ff <= voice_valid_ff[raddr];
   end

   // voice memory: pointer and remaining count per voice
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         voice_mem[vwr_idx] <= vwr_data;
      end
      rd_entry_ff <= voice_mem[raddr];
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (swr_en) begin
         sample_mem[red_addr] <= data_ff;
      end
      smp_q_ff <= sample_mem[cur_ptr];
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      master_volume_in = master_volume_ff;
      if (cfg_wr && (csr_paddr[2] == REG_MASTER_VOLUME)) begin
         master_volume_in = csr_pwdata[VOL_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MASTER_VOLUME) begin
         csr_prdata = 32'(master_volume_ff);
      end
   end

   // scaling and output register
   svm_scale #(
      .SUM_W (SUM_W)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .sum_valid    (sum_valid),
      .sum_ready    (sum_ready),
      .sum          (acc_ff),
      .volume       (master_volume_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_dac_code (rsp_dac_code)
   );

   // a tick transfer starts the voice walk at the first voice
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_func == FUNC_TICK)) |=> ((state_ff == S_TICK) && (cnt_ff == '0)))
      else $error("tick did not start voice walk");

   // a sample fetch always follows a live voice read
   a_smp_after_read: assert property (@(posedge clock) disable iff (reset)
      smp_live_ff |-> $past(rd_live_ff))
      else $error("sample fetch without voice read");

   // the mix is handed on only once both read stages have drained
   a_hand_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HAND) |-> (!rd_live_ff && !smp_live_ff))
      else $error("mix handed on with reads in flight");

   // the voice memory is written only by a tick walk or a trigger
   a_voice_write: assert property (@(posedge clock) disable iff (reset)
      vwr_en |-> ((state_ff == S_TICK) || (state_ff == S_TRIG_WR)))
      else $error("voice memory written outside tick or trigger");

endmodule

FILE: tb/sample_voice_mixer_top_tb.sv
// self-checking testbench for the sample voice mixer top level
`timescale 1ns / 1ps

// mirror of the mixer state with the dac codes still to come
class voice_mix_checker;
   localparam int VOICE_COUNT = 16;

   logic [14:0]        volume;
   logic [15:0]        ptr [VOICE_COUNT];
   logic [15:0]        remaining [VOICE_COUNT];
   logic signed [15:0] samples [65536];
   bit                 written [65536];
   logic [11:0]        dac_codes_due [$];
   int                 errors;

   function new();
      volume = svm_pkg::VOL_RESET;
      errors = 0;
      foreach (ptr[v]) begin
         ptr[v] = '0;
         remaining[v] = '0;
      end
   endfunction

   function int pending();
      return dac_codes_due.size();
   endfunction

   // first word that an active voice is about to play but nobody has written
   function int unwritten_voice_word();
      for (int v = 0; v < VOICE_COUNT; v++)
         if (remaining[v] != 0 && !written[ptr[v]])
            return int'(ptr[v]);
      return -1;
   endfunction

   function void take_item(logic [1:0] f, logic [15:0] addr, logic [15:0] data,
                           logic [15:0] start, logic [15:0] len);
      int     pick;
      longint acc;
      longint scaled;
      case (f)
         svm_pkg::FUNC_LOAD: begin
            samples[addr] = data;
            written[addr] = 1'b1;
         end
         svm_pkg::FUNC_TRIGGER: begin
            // fewest samples left, lowest number on a tie
            pick = 0;
            for (int v = 1; v < VOICE_COUNT; v++)
               if (remaining[v] < remaining[pick])
                  pick = v;
            ptr[pick] = start;
            remaining[pick] = len;
         end
         svm_pkg::FUNC_TICK: begin
            acc = 0;
            for (int v = 0; v < VOICE_COUNT; v++)
               if (remaining[v] != 0) begin
                  acc += longint'(samples[ptr[v]]);
                  ptr[v] = ptr[v] + 16'd1;
                  remaining[v] = remaining[v] - 16'd1;
               end
            scaled = (acc * longint'({1'b0, volume})) >>> svm_pkg::FRAC_BITS;
            if (scaled > svm_pkg::CLAMP_MAX)
               scaled = svm_pkg::CLAMP_MAX;
            if (scaled < svm_pkg::CLAMP_MIN)
               scaled = svm_pkg::CLAMP_MIN;
            dac_codes_due.push_back(12'(scaled + svm_pkg::DAC_OFFSET));
         end
         default: ;
      endcase
   endfunction

   function void check_dac_code(logic [11:0] got);
      logic [11:0] want;
      if (dac_codes_due.size() == 0) begin
         $display("%0t: dac_code with none expected: expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = dac_codes_due.pop_front();
      if (got !== want) begin
         $display("%0t: dac_code mismatch: expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module sample_voice_mixer_top_tb;
   import svm_pkg::*;

   localparam int VOICE_COUNT  = 16;
   localparam int MEMORY_WORDS = 65536;
   localparam int PHASE_ITEMS  = 75;
   localparam int PHASES       = 6;
   // quiet time before a register write or the end: covers a full voice scan or tick
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 500000;
   // func code 3 is outside the enum and must be ignored by the block
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_TICK;
   logic [15:0]        req_mem_address = '0;
   logic signed [15:0] req_mem_data = '0;
   logic [15:0]        req_voice_start = '0;
   logic [15:0]        req_voice_length = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [11:0]        rsp_dac_code;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int                 req_idle_pct = 33;
   int                 rsp_stall_pct = 33;
   int                 cycle_count = 0;
   // every accepted input transfer, gap-filling loads included
   int                 items_sent = 0;

   voice_mix_checker   sb = new();

   sample_voice_mixer_top #(
      .VOICES       (VOICE_COUNT),
      .SAMPLE_WORDS (MEMORY_WORDS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .req_voice_start  (req_voice_start),
      .req_voice_length (req_voice_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_code     (rsp_dac_code),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // result transfers, sampled as they stood just before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_dac_code(rsp_dac_code);
   end

   // one input transfer, with optional idle cycles in front; the item is
   // handed to the checker at the edge that accepts it
   task automatic send_item(input logic [1:0] f, input logic [15:0] addr,
                            input logic [15:0] data, input logic [15:0] start,
                            input logic [15:0] len);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_mem_address  <= addr;
      req_mem_data     <= data;
      req_voice_start  <= start;
      req_voice_length <= len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.take_item(f, addr, data, start, len);
      items_sent++;
   endtask

   // a tick, preceded by loads of any word an active voice would read unwritten
   task automatic play_tick();
      int gap;
      gap = sb.unwritten_voice_word();
      while (gap >= 0) begin
         send_item(FUNC_LOAD, gap[15:0], 16'($urandom), 16'($urandom), 16'($urandom));
         gap = sb.unwritten_voice_word();
      end
      send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // drop valid, wait for every dac code, then let the block fall idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access cycle; junk in the bits above the register width
   task automatic write_volume(input logic [14:0] vol);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_MASTER_VOLUME, 2'b00};
      csr_pwdata  <= {17'($urandom), vol};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.volume = vol;
   endtask

   // mostly inside a small window so voices play written words
   function automatic logic [15:0] near_addr();
      return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 511)) : 16'($urandom);
   endfunction

   initial begin
      int          n;
      int          roll;
      logic [15:0] len;
      logic [14:0] vol;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_volume(VOL_RESET);

      // directed part at unity gain
      // unused func code is dropped without a result
      send_item(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      // nothing playing: silence
      play_tick();
      // words either side of the memory wrap, both full-scale values among them
      send_item(FUNC_LOAD, 16'hFFFE, 16'hFFFF, 16'($urandom), 16'($urandom));
      send_item(FUNC_LOAD, 16'hFFFF, 16'h7FFF, 16'($urandom), 16'($urandom));
      send_item(FUNC_LOAD, 16'h0000, 16'h8000, 16'($urandom), 16'($urandom));
      send_item(FUNC_LOAD, 16'h0001, 16'h04D2, 16'($urandom), 16'($urandom));
      // voice 0 plays across the wrap
      send_item(FUNC_TRIGGER, 16'($urandom), 16'($urandom), 16'hFFFE, 16'd4);
      // zero length leaves the chosen voice idle
      send_item(FUNC_TRIGGER, 16'($urandom), 16'($urandom), 16'h0000, 16'd0);
      play_tick();
      play_tick();
      // longest possible voice, summing with voice 0 into negative clamp
      send_item(FUNC_TRIGGER, 16'($urandom), 16'($urandom), 16'h0000, 16'hFFFF);
      play_tick();
      play_tick();
      // start at the top address
      send_item(FUNC_TRIGGER, 16'($urandom), 16'($urandom), 16'hFFFF, 16'd1);
      play_tick();
      play_tick();
      play_tick();

      // random phases, each at its own gain
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: vol = 15'h7FFF;
            1: vol = 15'h0000;
            2: vol = VOL_RESET;
            3: vol = 15'd1;
            4: vol = 15'($urandom);
            default: vol = 15'($urandom_range(4096, 32767));
         endcase
         write_volume(vol);
         // one phase runs flat out on both sides
         req_idle_pct  = (phase == 2) ? 0 : 33;
         rsp_stall_pct = (phase == 2) ? 0 : 33;
         n = items_sent;
         while (items_sent - n < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               send_item(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end else begin
               if (roll < 30) begin
                  send_item(FUNC_LOAD, near_addr(), 16'($urandom), 16'($urandom),
                            16'($urandom));
               end else if (roll < 60) begin
                  // short voices mostly, so that all sixteen fill up and get stolen
                  roll = $urandom_range(0, 99);
                  if (roll < 5)
                     len = 16'd0;
                  else if (roll < 8)
                     len = 16'($urandom);
                  else
                     len = 16'($urandom_range(1, 48));
                  send_item(FUNC_TRIGGER, 16'($urandom), 16'($urandom), near_addr(), len);
               end else begin
                  play_tick();
               end
            end
         end
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
hdl/svm_pkg.sv
hdl/svm_scale.sv
hdl/sample_voice_mixer_top.sv
tb/sample_voice_mixer_top_tb.sv
